// ----- hdl/crc32c_pkg.sv -----
// constants and the byte-wide update function for the msb-first crc-32 checker
package crc32c_pkg;

    localparam int unsigned CRC_W     = 32;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CNT_W     = 3;
    localparam int unsigned APB_AW    = 3;
    localparam int unsigned APB_DW    = 32;

    localparam logic [CRC_W-1:0] CRC_POLY     = 32'h04C1_1DB7;
    localparam logic [CNT_W-1:0] CHK_CNT_FULL = 3'd4;
    localparam logic [CNT_W-1:0] CHK_CNT_SAT  = 3'd7;

    // register index decoded from paddr[2]
    localparam logic REG_CRC_SEED = 1'b0;

    // one byte folded in msb first, eight unrolled bit steps
    function automatic logic [CRC_W-1:0] crc_fold_byte(input logic [CRC_W-1:0] crc,
                                                       input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] r;
        r = crc ^ {data, {(CRC_W-BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++) begin
            if (r[CRC_W-1]) begin
                r = {r[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[CRC_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

// ----- hdl/crc32_msb_first_check_top.sv -----
// top level of the msb-first crc-32 frame checker with stream ports and apb seed register
// path: an accepted byte is held in the input register; if it ends a frame, its result is
//   registered in the result register and raised on m_tvalid once the result slot is free
// throughput: one byte per cycle; the crc update is one byte-wide fold between input and state
//   registers, and only a stalled result register holds back the input register
// reset: aresetn is synchronous, active low; clears crc, stored crc, check count, seed and valids
module crc32_msb_first_check_top
    import crc32c_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    // input byte stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [BYTE_W-1:0]   s_tdata,   // [7:0] data_byte
    input  logic [1:0]          s_tuser,   // [0] first_byte, [1] check_byte
    input  logic                s_tlast,   // last byte of the frame

    // result stream, one request per frame
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [CRC_W-1:0]    m_tdata,   // [31:0] crc_value
    output logic                m_tuser,   // [0] crc_match

    // apb configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    // seed register
    logic [CRC_W-1:0] seed_reg;

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_first_reg;
    logic              in_check_reg;
    logic              in_last_reg;

    // frame state
    logic [CRC_W-1:0] crc_reg,       crc_next;
    logic [CRC_W-1:0] stored_reg,    stored_next;
    logic [CNT_W-1:0] chk_cnt_reg,   chk_cnt_next;

    // result register
    logic              out_valid_reg;
    logic [CRC_W-1:0]  out_crc_reg;
    logic              out_match_reg;

    logic out_free;
    logic advance;
    logic cfg_write;

    // config port: writes complete in the access phase, no wait states
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_CRC_SEED) ? seed_reg : '0;

    // result register can take a new request when empty or being drained
    assign out_free = !out_valid_reg || m_tready;
    // input byte is processed unless it ends a frame and the result slot is blocked
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    // frame start reload, then either fold a data byte or gather a check byte
    always_comb begin
        logic [CRC_W-1:0] crc_base;
        logic [CRC_W-1:0] stored_base;
        logic [CNT_W-1:0] cnt_base;
        crc_base    = in_first_reg ? seed_reg : crc_reg;
        stored_base = in_first_reg ? '0       : stored_reg;
        cnt_base    = in_first_reg ? '0       : chk_cnt_reg;

        crc_next     = crc_base;
        stored_next  = stored_base;
        chk_cnt_next = cnt_base;
        if (in_check_reg) begin
            // little-endian gather, bytes after the fourth are dropped
            if (cnt_base < CHK_CNT_FULL) begin
                case (cnt_base[1:0])
                    2'd0:    stored_next[7:0]   = in_byte_reg;
                    2'd1:    stored_next[15:8]  = in_byte_reg;
                    2'd2:    stored_next[23:16] = in_byte_reg;
                    default: stored_next[31:24] = in_byte_reg;
                endcase
            end
            if (cnt_base != CHK_CNT_SAT) begin
                chk_cnt_next = cnt_base + 1'b1;
            end
        end else begin
            crc_next = crc_fold_byte(crc_base, in_byte_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg      <= '0;
            in_valid_reg  <= 1'b0;
            crc_reg       <= '0;
            stored_reg    <= '0;
            chk_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_write && paddr[2] == REG_CRC_SEED) begin
                seed_reg <= pwdata;
            end

            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end

            if (advance) begin
                crc_reg     <= crc_next;
                stored_reg  <= stored_next;
                chk_cnt_reg <= chk_cnt_next;
            end

            if (advance && in_last_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser[0];
            in_check_reg <= s_tuser[1];
            in_last_reg  <= s_tlast;
        end
        if (advance && in_last_reg) begin
            out_crc_reg   <= crc_next;
            out_match_reg <= (chk_cnt_next == CHK_CNT_FULL) && (stored_next == crc_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_crc_reg;
    assign m_tuser  = out_match_reg;

    // a byte held back in the input register stays there unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg)
            && $stable(in_last_reg))
        else $error("input register lost or changed a held byte");

    // a frame end is only processed when the result slot can take it
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg |-> !out_valid_reg || m_tready)
        else $error("result overwritten before it was taken");

    // frame state only moves when a byte is processed
    assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(crc_reg) && $stable(chk_cnt_reg) && $stable(stored_reg))
        else $error("frame state changed without a processed byte");

    // a match needs exactly four gathered check bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg && chk_cnt_next != CHK_CNT_FULL |=> !out_match_reg)
        else $error("match flagged without four check bytes");

endmodule
